// ===== design/line_voxel_walker_3d_macros.svh =====
// assertion helpers for the line voxel walker checker
`ifndef LINE_VOXEL_WALKER_3D_MACROS_SVH
`define LINE_VOXEL_WALKER_3D_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LVW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("line voxel walker check failed");

// consequent must hold in the cycle after the antecedent
`define LVW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("line voxel walker check failed");

`endif

// ===== design/lvw_pkg.sv =====
package lvw_pkg;

    // payload field widths
    localparam int COORD_W = 32;
    localparam int ID_W    = 8;
    localparam int META_W  = 4;

    // stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 112;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // minor axes per major axis: first minor at [major], second at [major + 3]
    localparam logic [1:0] AXIS_PAIRS [6] = '{AXIS_Z, AXIS_X, AXIS_X, AXIS_Y, AXIS_Z, AXIS_Y};

    // last count of the delta setup sequence (three axes, two phases each)
    localparam logic [2:0] SETUP_LAST = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PICK,
        ST_WALK
    } lvw_state_t;

    // minor coordinate move for one step
    typedef struct packed {
        logic inc;
        logic dec;
    } lvw_carry_t;

endpackage

// ===== design/lvw_setup.sv =====
module lvw_setup #(
    parameter int COORD_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [2:0][COORD_BITS-1:0] start_pos,
    input  logic [2:0][COORD_BITS-1:0] end_pos,
    output logic                       done,
    output logic [2:0][COORD_BITS:0]   delta,
    output logic [1:0]                 major_idx,
    output logic [COORD_BITS:0]        major_abs
);

    localparam int DW = COORD_BITS + 1;

    logic                 busy_reg;
    logic [2:0]           cnt_reg;
    logic signed [DW-1:0] diff_reg;
    logic [2:0][DW-1:0]   delta_reg;
    logic [1:0]           best_idx_reg;
    logic [DW-1:0]        best_abs_reg;

    logic [1:0]           axis;
    logic                 phase_abs;
    logic signed [DW-1:0] op_a;
    logic signed [DW-1:0] op_b;
    logic signed [DW-1:0] sum;
    logic [DW-1:0]        abs_val;
    logic                 take;

    // shared subtractor: end - start on even counts, 0 - diff on odd counts
    always_comb begin
        axis      = cnt_reg[2:1];
        phase_abs = cnt_reg[0];
        op_a      = phase_abs ? '0 : DW'(signed'(end_pos[axis]));
        op_b      = phase_abs ? diff_reg : DW'(signed'(start_pos[axis]));
        sum       = op_a - op_b;
        abs_val   = diff_reg[DW-1] ? sum : diff_reg;
        take      = abs_val > best_abs_reg;
    end

    // sequence counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == lvw_pkg::SETUP_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // delta capture and strict-greater major pick, lowest axis wins ties
    always_ff @(posedge aclk) begin
        if (start) begin
            best_abs_reg <= '0;
            best_idx_reg <= lvw_pkg::AXIS_X;
        end else if (busy_reg) begin
            if (!phase_abs) begin
                diff_reg <= sum;
            end else begin
                delta_reg[axis] <= diff_reg;
                if (take) begin
                    best_abs_reg <= abs_val;
                    best_idx_reg <= axis;
                end
            end
        end
    end

    assign done      = busy_reg && (cnt_reg == lvw_pkg::SETUP_LAST);
    assign delta     = delta_reg;
    assign major_idx = best_idx_reg;
    assign major_abs = best_abs_reg;

endmodule

// ===== design/lvw_minor_step.sv =====
module lvw_minor_step #(
    parameter int SPAN_W = 6
) (
    input  logic signed [SPAN_W+2:0] err,
    input  logic signed [SPAN_W+1:0] two_delta,
    input  logic [SPAN_W:0]          two_span,
    output logic signed [SPAN_W+2:0] err_next,
    output lvw_pkg::lvw_carry_t      carry
);

    localparam int RW = SPAN_W + 3;

    logic signed [RW-1:0] sum;
    logic signed [RW-1:0] span_ext;

    // remainder update with a single wrap in either direction
    always_comb begin
        span_ext  = {2'b00, two_span};
        sum       = err + RW'(two_delta);
        carry.inc = 1'b0;
        carry.dec = 1'b0;
        err_next  = sum;
        if (sum < 0) begin
            err_next  = sum + span_ext;
            carry.dec = 1'b1;
        end else if (sum >= span_ext) begin
            err_next  = sum - span_ext;
            carry.inc = 1'b1;
        end
    end

endmodule

// ===== design/line_voxel_walker_3d.sv =====
// first voxel path: request capture, ST_SETUP deltas, ST_PICK walk load, output register
// throughput: a line of major span n gives n + 1 voxels, one per cycle while m_tready is high
// a new request is taken only once the sequencer is back in idle; setup uses the shared subtractor
// a zero-length line gives no voxel, a too-long line gives one flagged voxel
// reset: synchronous active-low aresetn clears the sequencer and the output valid
module line_voxel_walker_3d #(
    parameter int MAX_SPAN   = 63,
    parameter int COORD_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // start_x, start_y, start_z, end_x, end_y, end_z, block_id, block_meta
    input  logic [lvw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // voxel_x, voxel_y, voxel_z, out_block_id, out_block_meta
    output logic [lvw_pkg::M_TDATA_W-1:0]   m_tdata,
    // too_long
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    localparam int CB     = COORD_BITS;
    localparam int DW     = COORD_BITS + 1;
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int RW     = SPAN_W + 3;
    localparam int CW     = lvw_pkg::COORD_W;

    lvw_pkg::lvw_state_t state_reg, state_next;

    logic [2:0][CB-1:0]          pos_reg;
    logic [2:0][CB-1:0]          end_reg;
    logic [lvw_pkg::ID_W-1:0]    id_reg;
    logic [lvw_pkg::META_W-1:0]  meta_reg;
    logic [1:0]                  major_reg;
    logic [1:0]                  a1_reg;
    logic [1:0]                  a2_reg;
    logic                        neg_reg;
    logic [SPAN_W-1:0]           remain_reg;
    logic [SPAN_W:0]             two_n_reg;
    logic signed [SPAN_W+1:0]    two_d1_reg;
    logic signed [SPAN_W+1:0]    two_d2_reg;
    logic signed [RW-1:0]        err1_reg;
    logic signed [RW-1:0]        err2_reg;

    logic                        out_valid_reg;
    logic [CW-1:0]               out_x_reg;
    logic [CW-1:0]               out_y_reg;
    logic [CW-1:0]               out_z_reg;
    logic [lvw_pkg::ID_W-1:0]    out_id_reg;
    logic [lvw_pkg::META_W-1:0]  out_meta_reg;
    logic                        out_long_reg;
    logic                        out_last_reg;

    logic                        in_acc;
    logic                        can_load;
    logic                        load_long;
    logic                        load_voxel;
    logic                        walk_init;

    logic                        setup_done;
    logic [2:0][DW-1:0]          delta;
    logic [1:0]                  major_idx;
    logic [DW-1:0]               major_abs;

    logic [1:0]                  a1_sel;
    logic [1:0]                  a2_sel;
    logic [SPAN_W-1:0]           span_n;
    logic signed [RW-1:0]        err1_next;
    logic signed [RW-1:0]        err2_next;
    lvw_pkg::lvw_carry_t         carry1;
    lvw_pkg::lvw_carry_t         carry2;
    logic [2:0][CB-1:0]          pos_next;

    // shared delta and major-axis unit
    lvw_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_acc),
        .start_pos (pos_reg),
        .end_pos   (end_reg),
        .done      (setup_done),
        .delta     (delta),
        .major_idx (major_idx),
        .major_abs (major_abs)
    );

    // minor axis remainder steppers
    lvw_minor_step #(
        .SPAN_W(SPAN_W)
    ) u_step1 (
        .err       (err1_reg),
        .two_delta (two_d1_reg),
        .two_span  (two_n_reg),
        .err_next  (err1_next),
        .carry     (carry1)
    );

    lvw_minor_step #(
        .SPAN_W(SPAN_W)
    ) u_step2 (
        .err       (err2_reg),
        .two_delta (two_d2_reg),
        .two_span  (two_n_reg),
        .err_next  (err2_next),
        .carry     (carry2)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lvw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer
    always_comb begin
        s_tready   = (state_reg == lvw_pkg::ST_IDLE);
        in_acc     = s_tvalid && s_tready;
        can_load   = !out_valid_reg || m_tready;
        load_long  = 1'b0;
        load_voxel = 1'b0;
        walk_init  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            lvw_pkg::ST_IDLE: begin
                if (in_acc) begin
                    state_next = lvw_pkg::ST_SETUP;
                end
            end
            lvw_pkg::ST_SETUP: begin
                if (setup_done) begin
                    state_next = lvw_pkg::ST_PICK;
                end
            end
            lvw_pkg::ST_PICK: begin
                if (major_abs == '0) begin
                    state_next = lvw_pkg::ST_IDLE;
                end else if (major_abs > DW'(MAX_SPAN)) begin
                    if (can_load) begin
                        load_long  = 1'b1;
                        state_next = lvw_pkg::ST_IDLE;
                    end
                end else begin
                    walk_init  = 1'b1;
                    state_next = lvw_pkg::ST_WALK;
                end
            end
            lvw_pkg::ST_WALK: begin
                if (can_load) begin
                    load_voxel = 1'b1;
                    if (remain_reg == '0) begin
                        state_next = lvw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = lvw_pkg::ST_IDLE;
            end
        endcase
    end

    // walk setup values taken from the picked major axis
    always_comb begin
        a1_sel = lvw_pkg::AXIS_PAIRS[major_idx];
        a2_sel = lvw_pkg::AXIS_PAIRS[3'({1'b0, major_idx}) + 3'd3];
        span_n = major_abs[SPAN_W-1:0];
    end

    // next voxel position: major moves one unit, minors follow their carries
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_next[i] = pos_reg[i];
            if (2'(i) == major_reg) begin
                pos_next[i] = neg_reg ? pos_reg[i] - CB'(1) : pos_reg[i] + CB'(1);
            end else if (2'(i) == a1_reg) begin
                if (carry1.inc) begin
                    pos_next[i] = pos_reg[i] + CB'(1);
                end else if (carry1.dec) begin
                    pos_next[i] = pos_reg[i] - CB'(1);
                end
            end else if (2'(i) == a2_reg) begin
                if (carry2.inc) begin
                    pos_next[i] = pos_reg[i] + CB'(1);
                end else if (carry2.dec) begin
                    pos_next[i] = pos_reg[i] - CB'(1);
                end
            end
        end
    end

    // request capture and walk state
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= s_tdata[CW*i +: CB];
                end_reg[i] <= s_tdata[CW*(i+3) +: CB];
            end
            id_reg   <= s_tdata[6*CW +: lvw_pkg::ID_W];
            meta_reg <= s_tdata[6*CW+lvw_pkg::ID_W +: lvw_pkg::META_W];
        end else if (walk_init) begin
            major_reg  <= major_idx;
            a1_reg     <= a1_sel;
            a2_reg     <= a2_sel;
            neg_reg    <= delta[major_idx][DW-1];
            remain_reg <= span_n;
            two_n_reg  <= {span_n, 1'b0};
            two_d1_reg <= {delta[a1_sel][SPAN_W:0], 1'b0};
            two_d2_reg <= {delta[a2_sel][SPAN_W:0], 1'b0};
            err1_reg   <= {3'b000, span_n};
            err2_reg   <= {3'b000, span_n};
        end else if (load_voxel && (remain_reg != '0)) begin
            remain_reg <= remain_reg - SPAN_W'(1);
            err1_reg   <= err1_next;
            err2_reg   <= err2_next;
            pos_reg    <= pos_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_long || load_voxel) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (load_long) begin
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_z_reg    <= '0;
            out_id_reg   <= id_reg;
            out_meta_reg <= meta_reg;
            out_long_reg <= 1'b1;
            out_last_reg <= 1'b1;
        end else if (load_voxel) begin
            out_x_reg    <= CW'(signed'(pos_reg[0]));
            out_y_reg    <= CW'(signed'(pos_reg[1]));
            out_z_reg    <= CW'(signed'(pos_reg[2]));
            out_id_reg   <= id_reg;
            out_meta_reg <= meta_reg;
            out_long_reg <= 1'b0;
            out_last_reg <= (remain_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_long_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_meta_reg, out_id_reg, out_z_reg, out_y_reg, out_x_reg};

endmodule

// ===== design/lvw_checker.sv =====
`include "line_voxel_walker_3d_macros.svh"

module lvw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [lvw_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lvw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // a stalled result stays offered
    `LVW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // one request at a time: ready drops after a request transaction
    `LVW_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)

    // a too-long flag ends its run
    `LVW_ASSERT_SAME(a_long_is_last, m_tvalid && m_tuser, m_tlast)

    // a too-long result carries zero coordinates
    `LVW_ASSERT_SAME(a_long_zero, m_tvalid && m_tuser, m_tdata[95:0] == 96'd0)

endmodule

bind line_voxel_walker_3d lvw_checker u_lvw_checker (.*);
